// ===== sv/bbf_pkg.sv =====
// ---------------------------------------------------------------------------
// bbf_pkg: shared types and constants for the byte batcher
// Store geometry, register and mode codes, and the sequencer state type.
// ---------------------------------------------------------------------------
package bbf_pkg;

    localparam int STORE_DEPTH  = 64;
    localparam int PACKET_LIMIT = 64;
    localparam int PTR_W        = $clog2(STORE_DEPTH);
    localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
    localparam int BATCH_CAP    = (STORE_DEPTH < PACKET_LIMIT) ? STORE_DEPTH : PACKET_LIMIT;

    localparam int BATCH_W      = 7;
    localparam int TIMEOUT_W    = 8;
    localparam int IDLE_W       = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'b1;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } state_t;

endpackage

// ===== sv/byte_batcher_with_idle_flush.sv =====
// ---------------------------------------------------------------------------
// byte_batcher_with_idle_flush: byte store with batch and idle-timeout flush
// Collects bytes in a ring store and emits them as packets with an end mark.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, mode, data_byte): mode 0 stores a
//   received byte, mode 1 reports one time tick. Output channel
//   (out_valid/out_ready, out_byte, end_of_packet) carries packet bytes,
//   end_of_packet high on the last one. Configuration: cfg_we with
//   cfg_index 0 sets batch_size, index 1 sets idle_timeout.
//   An item is taken when no packet is in flight. If it completes a
//   batch (or a tick meets the idle timeout with bytes waiting), a packet
//   of N bytes follows: each byte passes a synchronous store read step
//   and then a display step, where it waits for the receiver. in_ready
//   stays low until the last byte is taken. A receiver stall holds the
//   current byte and stretches the burst.
//   Reset empties the store (fill count and pointer to zero), clears the
//   idle counter and loads batch_size 64, idle_timeout 2. No clearing
//   pass: store entries are only read after being written.
// ---------------------------------------------------------------------------
module byte_batcher_with_idle_flush (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [7:0]                      data_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            end_of_packet,
    input  logic                            cfg_we,
    input  logic [bbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bbf_pkg::*;

    localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W+1)'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(STORE_DEPTH);
    localparam logic [BATCH_W-1:0] CAP_B  = BATCH_W'(BATCH_CAP);
    localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(BATCH_CAP);
    localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);

    state_t                 state_reg, state_next;
    logic [BATCH_W-1:0]     batch_size_reg;
    logic [TIMEOUT_W-1:0]   idle_timeout_reg;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [IDLE_W-1:0]      idle_reg, idle_next;
    logic [CNT_W-1:0]       remain_reg, remain_next;

    logic [7:0]             store_mem [STORE_DEPTH];
    logic [7:0]             store_q;

    logic                   in_take, out_take, is_byte, store_we;
    logic [CNT_W-1:0]       batch_eff, fill_w, count;
    logic [IDLE_W-1:0]      idle_w;
    logic [PTR_W:0]         wsum;
    logic [PTR_W-1:0]       waddr;
    logic                   rd_en;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;
    assign is_byte  = (mode == MODE_BYTE);

    // clamp batch size to 1..BATCH_CAP
    always_comb
    begin
        if (batch_size_reg == '0)
        begin
            batch_eff = ONE_C;
        end
        else if (batch_size_reg > CAP_B)
        begin
            batch_eff = CAP_C;
        end
        else
        begin
            batch_eff = CNT_W'(batch_size_reg);
        end
    end

    // item evaluation: write slot, new fill, idle count, packet length
    always_comb
    begin
        store_we = in_take && is_byte && (fill_reg < DEPTH_C);
        wsum     = (PTR_W+1)'(rd_ptr_reg) + (PTR_W+1)'(fill_reg);
        if (wsum >= DEPTH_W)
        begin
            wsum = wsum - DEPTH_W;
        end
        waddr  = wsum[PTR_W-1:0];
        fill_w = (is_byte && (fill_reg < DEPTH_C)) ? fill_reg + ONE_C : fill_reg;
        if (is_byte)
        begin
            idle_w = '0;
        end
        else if (idle_reg < IDLE_MAX)
        begin
            idle_w = idle_reg + IDLE_W'(1);
        end
        else
        begin
            idle_w = idle_reg;
        end
        if (fill_w >= batch_eff)
        begin
            count = batch_eff;
        end
        else if (!is_byte && (fill_w != '0) && (idle_w >= idle_timeout_reg))
        begin
            count = fill_w;
        end
        else
        begin
            count = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (count != '0))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_take)
                begin
                    state_next = (remain_reg == ONE_C) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        rd_en         = 1'b0;
        rd_ptr_next   = rd_ptr_reg;
        fill_next     = fill_reg;
        idle_next     = idle_reg;
        remain_next   = remain_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_take)
                begin
                    fill_next   = fill_w - count;
                    idle_next   = idle_w;
                    remain_next = count;
                end
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_take)
                begin
                    remain_next = remain_reg - ONE_C;
                    rd_ptr_next = (rd_ptr_reg == PTR_W'(STORE_DEPTH - 1)) ?
                                  '0 : rd_ptr_reg + PTR_W'(1);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_byte      = store_q;
    assign end_of_packet = (remain_reg == ONE_C);

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[waddr] <= data_byte;
        end
        if (rd_en)
        begin
            store_q <= store_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            batch_size_reg   <= BATCH_W'(64);
            idle_timeout_reg <= TIMEOUT_W'(2);
            rd_ptr_reg       <= '0;
            fill_reg         <= '0;
            idle_reg         <= '0;
            remain_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            idle_reg   <= idle_next;
            remain_reg <= remain_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BATCH_SIZE:   batch_size_reg   <= cfg_data[BATCH_W-1:0];
                    CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                    default:          batch_size_reg   <= batch_size_reg;
                endcase
            end
        end
    end

endmodule

// ===== sv/bbf_checker.sv =====
// ---------------------------------------------------------------------------
// bbf_checker: port-level checks for the byte batcher
// Watches the handshakes and the packet burst sequencing over time.
// ---------------------------------------------------------------------------
module bbf_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [7:0]                      out_byte,
    input  logic                            end_of_packet
);

    // a stalled byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(end_of_packet))
        else $error("stalled output byte changed");

    // no request taken while a packet is in flight
    a_no_in_during_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during packet burst");

    // the last byte returns the block to accepting requests
    a_eop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && end_of_packet |=> in_ready && !out_valid)
        else $error("block not idle after end of packet");

    // each middle byte is followed by a store read before the next byte shows
    a_read_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !end_of_packet |=> !out_valid && !in_ready ##1 out_valid)
        else $error("packet burst sequencing broken");

endmodule

bind byte_batcher_with_idle_flush bbf_checker u_bbf_checker (.*);
